// ----- sv/rsa_pkg.sv -----
// ---------------------------------------------------------------------------
// rsa_pkg: shared types and constants for the RSA modular exponent engine
// Holds the command codes, register indexes and the payload word types.
// ---------------------------------------------------------------------------
package rsa_pkg;

  localparam int unsigned PrimeBitsDefault = 32;
  localparam int unsigned WordBits         = 64;
  localparam int unsigned AddrBits         = 5;

  localparam logic [63:0] ExpReset = 64'd65537;
  localparam logic [31:0] PReset   = 32'd885320963;
  localparam logic [31:0] QReset   = 32'd238855417;

  // command codes
  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  // register indexes
  localparam logic [1:0] RegExp = 2'd0;
  localparam logic [1:0] RegP   = 2'd1;
  localparam logic [1:0] RegQ   = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [63:0] data_in;
  } req_t;

  typedef struct packed {
    logic [63:0] data_out;
    logic [63:0] private_exponent;
    logic        status;
  } rsp_t;

  // operations of the shared modular unit
  typedef enum logic [1:0] {
    OpMulMod = 2'd0,
    OpDivMod = 2'd1
  } op_e;

  // request (start and operation) to the shared unit
  typedef struct packed {
    logic        start;
    op_e         op;
  } unit_ctl_t;

endpackage

// ----- sv/rsa_modexp_engine.sv -----
// ---------------------------------------------------------------------------
// rsa_modexp_engine: textbook RSA encrypt/decrypt engine
// Configuration over APB; commands over start/busy; one result per command.
// ---------------------------------------------------------------------------
//  channel | signals                          | direction
//  config  | psel/penable/pwrite/paddr/pwdata | in (prdata/pready out)
//  command | start_i, busy_o, req_i           | in (busy_o out)
//  result  | valid_o, rsp_o                   | out, one cycle, no stall
// Encrypt reduces the message mod n, then runs a square for every exponent
// bit and a multiply for every set bit; decrypt first runs extended Euclid
// steps, each a divide, a reduction and a multiply, on the shared unit.
// The bit-serial shared arithmetic unit performs each of these operations.
// Reset restores the default exponent and primes. busy_o is high from the
// accept edge until the result strobe; the receiver cannot stall.
// ---------------------------------------------------------------------------
module rsa_modexp_engine #(
  parameter int unsigned PrimeBits = rsa_pkg::PrimeBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rsa_pkg::AddrBits-1:0]  paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready,
  input  logic                          start_i,
  input  rsa_pkg::req_t                 req_i,
  output logic                          busy_o,
  output logic                          valid_o,
  output rsa_pkg::rsp_t                 rsp_o
);

  logic [63:0] exp_q;
  logic [31:0] p_q, q_q;
  logic        wr;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign wr  = psel & penable & pwrite & pready;
  assign idx = paddr[4:3];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= rsa_pkg::ExpReset; p_q <= rsa_pkg::PReset; q_q <= rsa_pkg::QReset;
    end else if (wr) begin
      case (idx)
        rsa_pkg::RegExp: exp_q <= pwdata;
        rsa_pkg::RegP:   p_q   <= pwdata[31:0];
        rsa_pkg::RegQ:   q_q   <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rsa_pkg::RegExp: prdata = exp_q;
      rsa_pkg::RegP:   prdata = {32'd0, p_q};
      rsa_pkg::RegQ:   prdata = {32'd0, q_q};
      default:         prdata = '0;
    endcase
  end

  rsa_seq #(.PrimeBits(PrimeBits)) u_seq (
    .clk_i, .rst_ni, .start_i(start_i & ~busy_o), .req_i,
    .exp_i(exp_q), .p_i(p_q), .q_i(q_q),
    .busy_o, .valid_o, .rsp_o
  );

endmodule

// ----- sv/rsa_arith.sv -----
// ---------------------------------------------------------------------------
// rsa_arith: shared bit-serial modular multiply / long divide unit
// One bit per cycle: acc = a*b mod m (double-and-add, 64 steps) or
// quotient/remainder of a / m (restoring divide, 64 steps).
// ---------------------------------------------------------------------------
module rsa_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rsa_pkg::unit_ctl_t  ctl_i,
  input  logic [63:0]         a_i,
  input  logic [63:0]         b_i,
  input  logic [63:0]         m_i,
  output logic                done_o,
  output logic [63:0]         res_o,
  output logic [63:0]         quo_o
);

  logic [63:0] a_q, a_d, b_q, b_d, m_q, m_d, acc_q, acc_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        run_q, run_d, done_q, done_d;
  rsa_pkg::op_e op_q, op_d;

  logic [63:0] dbl, added, room1, room2;
  logic [64:0] rem_sh;

  always_comb begin
    // doubling and conditional add, both mod m
    room1  = m_q - acc_q;
    dbl    = (acc_q >= room1) ? (acc_q - room1) : (acc_q + acc_q);
    room2  = m_q - a_q;
    added  = (dbl >= room2) ? (dbl - room2) : (dbl + a_q);
    rem_sh = {acc_q, b_q[63]};
  end

  always_comb begin
    a_d = a_q; b_d = b_q; m_d = m_q; acc_d = acc_q;
    cnt_d = cnt_q; run_d = run_q; done_d = 1'b0; op_d = op_q;
    if (ctl_i.start) begin
      // divide takes its dividend from a
      a_d = a_i; b_d = (ctl_i.op == rsa_pkg::OpDivMod) ? a_i : b_i;
      m_d = m_i; acc_d = '0;
      cnt_d = 7'd64; run_d = 1'b1; op_d = ctl_i.op;
    end else if (run_q) begin
      if (op_q == rsa_pkg::OpMulMod) begin
        acc_d = b_q[63] ? added : dbl;
        b_d   = {b_q[62:0], 1'b0};
      end else begin
        // restoring divide: b shifts out dividend bits, collects quotient
        if (rem_sh >= {1'b0, m_q}) begin
          acc_d = 64'(rem_sh - {1'b0, m_q});
          b_d   = {b_q[62:0], 1'b1};
        end else begin
          acc_d = rem_sh[63:0];
          b_d   = {b_q[62:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        run_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; run_q <= 1'b0; done_q <= 1'b0; op_q <= rsa_pkg::OpMulMod;
    end else begin
      cnt_q <= cnt_d; run_q <= run_d; done_q <= done_d; op_q <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; m_q <= m_d; acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;
  assign quo_o  = b_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !run_q) else $error("unit started while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done longer than one cycle");
  a_cnt_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> cnt_q != 7'd0) else $error("running with zero count");

endmodule

// ----- sv/rsa_seq.sv -----
// ---------------------------------------------------------------------------
// rsa_seq: sequencer for modulus, inverse and exponentiation
// Forms n = p*q and phi on a local multiplier, drives the shared unit through
// extended Euclid and square-and-multiply, then presents one result word.
// ---------------------------------------------------------------------------
module rsa_seq #(
  parameter int unsigned PrimeBits = rsa_pkg::PrimeBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  rsa_pkg::req_t      req_i,
  input  logic [63:0]        exp_i,
  input  logic [31:0]        p_i,
  input  logic [31:0]        q_i,
  output logic               busy_o,
  output logic               valid_o,
  output rsa_pkg::rsp_t      rsp_o
);

  typedef enum logic [4:0] {
    StIdle, StN, StPhi, StCheck, StEmod, StEloop, StQmod, StTmul, StTsub,
    StPinit, StSq, StSqW, StMulW, StBase, StDone
  } state_e;

  state_e      state_q;
  logic        cmd_q;
  logic [63:0] msg_q, n_q, phi_q, r0_q, r1_q, t0_q, t1_q, qt_q, ex_q, acc_q, base_q;
  logic [63:0] d_q;
  logic [6:0]  bit_q;
  logic        busy_q, valid_q, st_q;
  rsa_pkg::rsp_t rsp_q;

  logic        issue_q;
  rsa_pkg::op_e iop_q;
  logic [63:0] ia_q, ib_q, im_q;
  rsa_pkg::unit_ctl_t ictl;
  logic [63:0] ures, uquo;
  logic        udone;

  logic [31:0] pm, qm;
  assign pm = p_i & 32'((64'd1 << PrimeBits) - 64'd1);
  assign qm = q_i & 32'((64'd1 << PrimeBits) - 64'd1);

  // shared unit takes the registered issue
  assign ictl.start = issue_q;
  assign ictl.op    = iop_q;

  rsa_arith u_arith (
    .clk_i, .rst_ni, .ctl_i(ictl), .a_i(ia_q), .b_i(ib_q), .m_i(im_q),
    .done_o(udone), .res_o(ures), .quo_o(uquo)
  );

  logic [63:0] pm1, qm1;
  assign pm1 = (pm != 32'd0) ? {32'd0, pm - 32'd1} : 64'd0;
  assign qm1 = (qm != 32'd0) ? {32'd0, qm - 32'd1} : 64'd0;

  // one 32x32 multiply forms n, then phi
  logic [63:0] prod;
  logic [31:0] mx, my;
  always_comb begin
    mx = pm; my = qm;
    if (state_q == StPhi) begin
      mx = pm1[31:0]; my = qm1[31:0];
    end
    prod = {32'd0, mx} * {32'd0, my};
  end

  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; busy_q <= 1'b0; valid_q <= 1'b0; issue_q <= 1'b0;
      iop_q <= rsa_pkg::OpMulMod;
      cmd_q <= 1'b0; msg_q <= '0; n_q <= '0; phi_q <= '0; r0_q <= '0; r1_q <= '0;
      t0_q <= '0; t1_q <= '0; qt_q <= '0; ex_q <= '0; acc_q <= '0; base_q <= '0;
      d_q <= '0; bit_q <= '0; st_q <= 1'b0; rsp_q <= '0;
      ia_q <= '0; ib_q <= '0; im_q <= '0;
    end else begin
      valid_q <= 1'b0;
      issue_q <= 1'b0;
      case (state_q)
        StIdle: if (start_i) begin
          cmd_q <= req_i.cmd; msg_q <= req_i.data_in; busy_q <= 1'b1;
          d_q <= '0; st_q <= 1'b0; state_q <= StN;
        end
        StN: begin
          n_q <= prod; state_q <= StPhi;
        end
        StPhi: begin
          phi_q <= prod;
          if (n_q == 64'd0) begin
            acc_q <= '0; st_q <= (cmd_q == rsa_pkg::CmdDecrypt);
            state_q <= StDone;
          end else if (cmd_q == rsa_pkg::CmdEncrypt) begin
            ex_q <= exp_i; state_q <= StBase;
            ia_q <= msg_q; im_q <= n_q;
            issue_q <= 1'b1; iop_q <= rsa_pkg::OpDivMod;
          end else state_q <= StCheck;
        end
        StCheck: if (phi_q < 64'd2) begin
          acc_q <= '0; st_q <= 1'b1; state_q <= StDone;
        end else begin
          // r1 = e mod phi
          ia_q <= exp_i; im_q <= phi_q; issue_q <= 1'b1; iop_q <= rsa_pkg::OpDivMod;
          r0_q <= phi_q; t0_q <= '0; t1_q <= 64'd1; state_q <= StEmod;
        end
        StEmod: if (udone) begin
          r1_q <= ures; state_q <= StEloop;
        end
        StEloop: if (r1_q == 64'd0) begin
          if (r0_q != 64'd1) begin
            acc_q <= '0; st_q <= 1'b1; state_q <= StDone;
          end else begin
            d_q <= t0_q; ex_q <= t0_q; state_q <= StBase;
            ia_q <= msg_q; im_q <= n_q; issue_q <= 1'b1; iop_q <= rsa_pkg::OpDivMod;
          end
        end else begin
          ia_q <= r0_q; im_q <= r1_q; issue_q <= 1'b1; iop_q <= rsa_pkg::OpDivMod;
          state_q <= StQmod;
        end
        StQmod: if (udone) begin
          // quotient and next remainder; reduce qt mod phi next
          qt_q <= uquo; r0_q <= r1_q; r1_q <= ures;
          ia_q <= uquo; im_q <= phi_q; issue_q <= 1'b1; iop_q <= rsa_pkg::OpDivMod;
          state_q <= StTmul;
        end
        StTmul: if (udone) begin
          ia_q <= ures; ib_q <= t1_q; im_q <= phi_q; issue_q <= 1'b1;
          iop_q <= rsa_pkg::OpMulMod; state_q <= StTsub;
        end
        StTsub: if (udone) begin
          t0_q <= t1_q;
          t1_q <= (t0_q >= ures) ? (t0_q - ures) : (t0_q + (phi_q - ures));
          state_q <= StEloop;
        end
        StBase: if (udone) begin
          base_q <= ures; acc_q <= (n_q == 64'd1) ? 64'd0 : 64'd1;
          bit_q <= 7'd64; state_q <= StSq;
        end
        StSq: if (bit_q == 7'd0) begin
          state_q <= StDone;
        end else begin
          ia_q <= acc_q; ib_q <= acc_q; im_q <= n_q; issue_q <= 1'b1;
          iop_q <= rsa_pkg::OpMulMod; state_q <= StSqW;
        end
        StSqW: if (udone) begin
          acc_q <= ures;
          if (ex_q[63]) begin
            ia_q <= base_q; ib_q <= ures; im_q <= n_q; issue_q <= 1'b1;
            iop_q <= rsa_pkg::OpMulMod; state_q <= StMulW;
          end else begin
            ex_q <= {ex_q[62:0], 1'b0}; bit_q <= bit_q - 7'd1; state_q <= StSq;
          end
        end
        StMulW: if (udone) begin
          acc_q <= ures; ex_q <= {ex_q[62:0], 1'b0}; bit_q <= bit_q - 7'd1;
          state_q <= StSq;
        end
        StDone: begin
          rsp_q.data_out <= st_q ? 64'd0 : acc_q;
          rsp_q.private_exponent <= st_q ? 64'd0 : d_q;
          rsp_q.status <= st_q;
          valid_q <= 1'b1; busy_q <= 1'b0; state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  a_busy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !busy_q) else $error("busy while idle");
  a_valid_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (state_q == StIdle)) else $error("result outside end");
  a_issue_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q |=> !issue_q) else $error("issue repeated");

endmodule

// ----- tb/sv/tb.sv -----
// ---------------------------------------------------------------------------
// tb: self-checking bench for the RSA modular exponent engine
// Writes the exponent and both primes over APB, streams encrypt/decrypt words
// through start/busy, and checks every result strobe against a local model of
// the modular arithmetic computed when each command word is accepted.
// ---------------------------------------------------------------------------
module tb;

  localparam int unsigned CycleLimit = 30_000_000;
  localparam int unsigned DrainCycles = 200;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [rsa_pkg::AddrBits-1:0] paddr = '0;
  logic [63:0]                  pwdata = '0;
  logic [63:0]                  prdata;
  logic                         pready;
  logic                         start_i = 1'b0;
  rsa_pkg::req_t                req_i = '0;
  logic                         busy_o;
  logic                         valid_o;
  rsa_pkg::rsp_t                rsp_o;

  rsa_modexp_engine i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start_i, .req_i, .busy_o, .valid_o, .rsp_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register mirror
  logic [63:0] cfg_exponent = rsa_pkg::ExpReset;
  logic [31:0] cfg_p = rsa_pkg::PReset;
  logic [31:0] cfg_q = rsa_pkg::QReset;

  rsa_pkg::req_t cmd_pending_q[$];
  rsa_pkg::rsp_t rsp_expected_q[$];
  int unsigned idle_pct = 0;
  int unsigned errors = 0;
  int unsigned n_enc = 0, n_dec = 0, n_fail_status = 0, n_phases = 0;
  longint unsigned cycles = 0;
  logic        accepted_q = 1'b0;

  // ---- modular arithmetic model ----
  function automatic logic [63:0] add_m(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [63:0] room;
    room = m - y;
    return (x >= room) ? x - room : x + y;
  endfunction

  function automatic logic [63:0] mul_m(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [63:0] acc;
    acc = '0;
    for (int i = 63; i >= 0; i--) begin
      acc = add_m(acc, acc, m);
      if (b[i]) acc = add_m(acc, a, m);
    end
    return acc;
  endfunction

  function automatic logic [63:0] pow_m(logic [63:0] base, logic [63:0] ex, logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    base = base % m;
    for (int i = 63; i >= 0; i--) begin
      acc = mul_m(acc, acc, m);
      if (ex[i]) acc = mul_m(acc, base, m);
    end
    return acc;
  endfunction

  // extended Euclid; returns 1 and the inverse when gcd is one
  function automatic bit inv_m(logic [63:0] e, logic [63:0] phi, output logic [63:0] inv);
    logic [63:0] r0, r1, t0, t1, qt, rn, tn, prod;
    r0 = phi; r1 = e % phi; t0 = '0; t1 = 64'd1; inv = '0;
    while (r1 != 0) begin
      qt = r0 / r1;
      rn = r0 - qt * r1;
      prod = mul_m(qt % phi, t1, phi);
      tn = (t0 >= prod) ? t0 - prod : t0 + (phi - prod);
      r0 = r1; r1 = rn; t0 = t1; t1 = tn;
    end
    if (r0 != 1) return 1'b0;
    inv = t0;
    return 1'b1;
  endfunction

  function automatic rsa_pkg::rsp_t rsa_result(rsa_pkg::req_t r);
    rsa_pkg::rsp_t o;
    logic [63:0]   p, q, n, pm, qm, phi, d;
    o = '0;
    p = {32'd0, cfg_p};
    q = {32'd0, cfg_q};
    n = p * q;
    if (r.cmd == rsa_pkg::CmdEncrypt) begin
      if (n != 0) o.data_out = pow_m(r.data_in, cfg_exponent, n);
    end else begin
      pm = (p > 0) ? p - 64'd1 : 64'd0;
      qm = (q > 0) ? q - 64'd1 : 64'd0;
      phi = pm * qm;
      if (phi < 2 || n == 0 || !inv_m(cfg_exponent, phi, d)) begin
        o.status = 1'b1;
      end else begin
        o.private_exponent = d;
        o.data_out = pow_m(r.data_in, d, n);
      end
    end
    return o;
  endfunction

  // ---- command driver ----
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !accepted_q) begin
        // word still waiting for acceptance
      end else if (cmd_pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        req_i   <= cmd_pending_q.pop_front();
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ---- monitor and checker ----
  always @(posedge clk_i) begin
    rsa_pkg::rsp_t exp_w;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
    accepted_q <= rst_ni && start_i && !busy_o;
    if (rst_ni && start_i && !busy_o) begin
      exp_w = rsa_result(req_i);
      rsp_expected_q.push_back(exp_w);
      if (req_i.cmd == rsa_pkg::CmdEncrypt) n_enc++; else n_dec++;
      if (exp_w.status) n_fail_status++;
    end
    if (rst_ni && valid_o) begin
      if (rsp_expected_q.size() == 0) begin
        $error("unexpected result word: data_out %h", rsp_o.data_out);
        errors++;
      end else begin
        exp_w = rsp_expected_q.pop_front();
        if (rsp_o.data_out !== exp_w.data_out) begin
          $error("data_out expected %h actual %h", exp_w.data_out, rsp_o.data_out);
          errors++;
        end
        if (rsp_o.private_exponent !== exp_w.private_exponent) begin
          $error("private_exponent expected %h actual %h",
                 exp_w.private_exponent, rsp_o.private_exponent);
          errors++;
        end
        if (rsp_o.status !== exp_w.status) begin
          $error("status expected %b actual %b", exp_w.status, rsp_o.status);
          errors++;
        end
      end
    end
  end

  // ---- stimulus helpers ----
  task automatic apb_write(logic [1:0] idx, logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= rsa_pkg::AddrBits'({idx, 3'b000}); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      rsa_pkg::RegExp: cfg_exponent = val;
      rsa_pkg::RegP:   cfg_p = val[31:0];
      rsa_pkg::RegQ:   cfg_q = val[31:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (cmd_pending_q.size() != 0 || start_i || rsp_expected_q.size() != 0 || busy_o);
  endtask

  task automatic set_keys(logic [63:0] e, logic [31:0] p, logic [31:0] q);
    wait_idle();
    apb_write(rsa_pkg::RegExp, e);
    apb_write(rsa_pkg::RegP, {32'd0, p});
    apb_write(rsa_pkg::RegQ, {32'd0, q});
    n_phases++;
  endtask

  task automatic push_cmd(logic c, logic [63:0] v);
    rsa_pkg::req_t r;
    r.cmd = c;
    r.data_in = v;
    cmd_pending_q.push_back(r);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return {32'd0, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  initial begin
    logic [63:0] e;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset keys: extremes of the message, both commands
    push_cmd(rsa_pkg::CmdEncrypt, 64'd0);
    push_cmd(rsa_pkg::CmdEncrypt, '1);
    push_cmd(rsa_pkg::CmdDecrypt, 64'd12345);
    push_cmd(rsa_pkg::CmdDecrypt, '1);

    // small textbook key
    set_keys(64'd3, 32'd11, 32'd17);
    push_cmd(rsa_pkg::CmdEncrypt, 64'd186);
    push_cmd(rsa_pkg::CmdDecrypt, 64'd42);
    push_cmd(rsa_pkg::CmdEncrypt, 64'd187);

    // exponent zero: encrypt gives one, decrypt not invertible
    set_keys(64'd0, 32'd13, 32'd7);
    push_cmd(rsa_pkg::CmdEncrypt, 64'd5);
    push_cmd(rsa_pkg::CmdDecrypt, 64'd5);

    // unit modulus, phi zero
    set_keys(64'd0, 32'd1, 32'd1);
    push_cmd(rsa_pkg::CmdEncrypt, 64'd9);
    push_cmd(rsa_pkg::CmdDecrypt, 64'd9);

    // zero modulus
    set_keys(64'd65537, 32'd0, 32'd101);
    push_cmd(rsa_pkg::CmdEncrypt, '1);
    push_cmd(rsa_pkg::CmdDecrypt, 64'd3);

    // phi below two
    set_keys(64'd1, 32'd2, 32'd2);
    push_cmd(rsa_pkg::CmdDecrypt, 64'd3);
    push_cmd(rsa_pkg::CmdEncrypt, 64'd3);

    // exponent a multiple of phi
    set_keys(64'd16, 32'd3, 32'd5);
    push_cmd(rsa_pkg::CmdDecrypt, 64'd7);

    // widest values; then a write past the register list is ignored
    set_keys('1, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
    apb_write(2'd3, 64'd77);
    push_cmd(rsa_pkg::CmdEncrypt, '1);
    push_cmd(rsa_pkg::CmdDecrypt, 64'hDEAD_BEEF_0123_4567);

    // random keys and words with rotating sender idling
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(2))
        0: e = 64'd65537;
        1: e = {32'd0, $urandom()} | 64'd1;
        default: e = {$urandom(), $urandom()};
      endcase
      if (ph == 0) e = 64'h5555_5555_5555_5555;
      if (ph == 1) e = 64'hAAAA_AAAA_AAAA_AAAB;
      set_keys(e, (ph % 3 == 0) ? $urandom_range(1000, 2) : $urandom(),
               (ph % 3 == 0) ? $urandom_range(1000, 2) : $urandom());
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 46;
        2: idle_pct = 35;
        default: idle_pct = 46;
      endcase
      for (int k = 0; k < 8; k++) push_cmd(1'($urandom_range(1)), rand_word());
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Ran %0d key settings: %0d encrypt and %0d decrypt words, %0d flagged.",
             n_phases, n_enc, n_dec, n_fail_status);
    if (errors == 0 && rsp_expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rsa_pkg.sv
sv/rsa_arith.sv
sv/rsa_seq.sv
sv/rsa_modexp_engine.sv
tb/sv/tb.sv
